>>> rtl/per_client_window_rate_limiter_core_defines.svh
// Assertion macros shared by the rate limiter RTL.
`ifndef PER_CLIENT_WINDOW_RATE_LIMITER_CORE_DEFINES_SVH
`define PER_CLIENT_WINDOW_RATE_LIMITER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PCWRL_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("pcwrl assertion failed");

// Next-cycle implication, disabled during reset.
`define PCWRL_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("pcwrl assertion failed");

`endif

>>> rtl/pcwrl_pkg.sv
package pcwrl_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   localparam int KEY_W   = 32;
   localparam int TIME_W  = 32;
   localparam int CNT_W   = 17;
   localparam int LIMIT_W = 16;
   localparam int WIN_W   = 31;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CNT_W-1:0] COUNT_MAX    = 17'd65536;
   localparam logic [WIN_W-1:0] WINDOW_RESET = 31'd60000;

   // register index, taken from paddr[2]
   localparam logic REG_LIMIT  = 1'b0;
   localparam logic REG_WINDOW = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic load;    // latch the transaction, clear search state
      logic sweep;   // examine the entry at the sweep index
      logic finish;  // commit table update, present result
   } cmd_type;

   typedef struct packed {
      logic last_entry;  // sweep index is at the final entry
      logic limit_off;   // limiting disabled
   } status_type;

endpackage

>>> rtl/pcwrl_csr.sv
module pcwrl_csr import pcwrl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [LIMIT_W-1:0]    limit_per_window,
   output logic [WIN_W-1:0]      window_ticks
);

   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [WIN_W-1:0]   window_ff, window_in;
   logic               wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      limit_in  = limit_ff;
      window_in = window_ff;
      if (wr_en) begin
         case (paddr[2])
            REG_LIMIT:  limit_in  = pwdata[LIMIT_W-1:0];
            REG_WINDOW: window_in = pwdata[WIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_LIMIT:  prdata = {{(CSR_DATA_W-LIMIT_W){1'b0}}, limit_ff};
         REG_WINDOW: prdata = {{(CSR_DATA_W-WIN_W){1'b0}}, window_ff};
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff  <= '0;
         window_ff <= WINDOW_RESET;
      end else begin
         limit_ff  <= limit_in;
         window_ff <= window_in;
      end
   end

   assign limit_per_window = limit_ff;
   assign window_ticks     = window_ff;

endmodule

>>> rtl/pcwrl_ctrl.sv
`include "per_client_window_rate_limiter_core_defines.svh"

module pcwrl_ctrl import pcwrl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      busy       = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = status.limit_off ? ST_UPDATE : ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (status.last_entry) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `PCWRL_ASSERT_NEXT(a_load_goes_busy, clock, reset, cmd.load, busy)
   `PCWRL_ASSERT_NEXT(a_finish_frees, clock, reset, cmd.finish, !busy)
   `PCWRL_ASSERT_IMPLIES(a_sweep_busy, clock, reset, state_ff == ST_SWEEP, busy)

endmodule

>>> rtl/pcwrl_datapath.sv
`include "per_client_window_rate_limiter_core_defines.svh"

module pcwrl_datapath import pcwrl_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic [LIMIT_W-1:0] limit_per_window,
   input  logic [WIN_W-1:0]   window_ticks,
   input  logic [KEY_W-1:0]   req_client_key,
   input  logic [TIME_W-1:0]  req_now_time,
   output logic               rsp_valid,
   output logic               rsp_allowed,
   output logic               rsp_untracked,
   output logic [CNT_W-1:0]   rsp_request_count
);

   // table
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [KEY_W-1:0]         key_arr_ff   [TABLE_ENTRIES];
   logic [CNT_W-1:0]         cnt_arr_ff   [TABLE_ENTRIES];
   logic [TIME_W-1:0]        start_arr_ff [TABLE_ENTRIES];
   logic                     tbl_wr_en;
   logic [IDX_W-1:0]         tbl_wr_idx;
   logic                     tbl_wr_alloc;
   logic [CNT_W-1:0]         tbl_wr_cnt;

   // transaction and search state
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   logic [CNT_W-1:0]  hit_cnt_ff, hit_cnt_in;
   logic              free_ff, free_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;

   // result
   logic             rsp_valid_ff, rsp_valid_in;
   logic             allowed_ff, allowed_in;
   logic             untracked_ff, untracked_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic [TIME_W-1:0] elapsed;
   logic              expired;
   logic              live;
   logic [CNT_W-1:0]  next_cnt;

   assign elapsed  = now_ff - start_arr_ff[idx_ff];
   assign expired  = elapsed > {{(TIME_W-WIN_W){1'b0}}, window_ticks};
   assign live     = valid_ff[idx_ff] && !expired;
   assign next_cnt = (hit_cnt_ff < COUNT_MAX) ? (hit_cnt_ff + 17'd1) : hit_cnt_ff;

   assign status.last_entry = (idx_ff == IDX_W'(TABLE_ENTRIES - 1));
   assign status.limit_off  = (limit_per_window == '0);

   always_comb begin
      valid_in     = valid_ff;
      key_in       = key_ff;
      now_in       = now_ff;
      idx_in       = idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_cnt_in   = hit_cnt_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      rsp_valid_in = 1'b0;
      allowed_in   = allowed_ff;
      untracked_in = untracked_ff;
      count_in     = count_ff;
      tbl_wr_en    = 1'b0;
      tbl_wr_idx   = hit_idx_ff;
      tbl_wr_alloc = 1'b0;
      tbl_wr_cnt   = next_cnt;

      if (cmd.load) begin
         key_in  = req_client_key;
         now_in  = req_now_time;
         idx_in  = '0;
         hit_in  = 1'b0;
         free_in = 1'b0;
      end

      if (cmd.sweep) begin
         // expiry and lookup in one pass: entries do not affect each other
         if (valid_ff[idx_ff] && expired) begin
            valid_in[idx_ff] = 1'b0;
         end
         if (live) begin
            if (!hit_ff && key_arr_ff[idx_ff] == key_ff) begin
               hit_in     = 1'b1;
               hit_idx_in = idx_ff;
               hit_cnt_in = cnt_arr_ff[idx_ff];
            end
         end else if (!free_ff) begin
            free_in     = 1'b1;
            free_idx_in = idx_ff;
         end
         idx_in = idx_ff + IDX_W'(1);
      end

      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         allowed_in   = 1'b1;
         untracked_in = 1'b0;
         count_in     = '0;
         if (status.limit_off) begin
            // table left untouched
         end else if (hit_ff) begin
            tbl_wr_en  = 1'b1;
            tbl_wr_idx = hit_idx_ff;
            count_in   = next_cnt;
            allowed_in = !(next_cnt > {{(CNT_W-LIMIT_W){1'b0}}, limit_per_window});
         end else if (free_ff) begin
            tbl_wr_en              = 1'b1;
            tbl_wr_idx             = free_idx_ff;
            tbl_wr_alloc           = 1'b1;
            tbl_wr_cnt             = 17'd1;
            valid_in[free_idx_ff]  = 1'b1;
            count_in               = 17'd1;
         end else begin
            untracked_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      now_ff       <= now_in;
      hit_idx_ff   <= hit_idx_in;
      hit_cnt_ff   <= hit_cnt_in;
      free_idx_ff  <= free_idx_in;
      allowed_ff   <= allowed_in;
      untracked_ff <= untracked_in;
      count_ff     <= count_in;
      if (tbl_wr_en) begin
         cnt_arr_ff[tbl_wr_idx] <= tbl_wr_cnt;
         if (tbl_wr_alloc) begin
            key_arr_ff[tbl_wr_idx]   <= key_ff;
            start_arr_ff[tbl_wr_idx] <= now_ff;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_allowed       = allowed_ff;
   assign rsp_untracked     = untracked_ff;
   assign rsp_request_count = count_ff;

   `PCWRL_ASSERT_NEXT(a_finish_strobes, clock, reset, cmd.finish, rsp_valid_ff)
   `PCWRL_ASSERT_IMPLIES(a_untracked_allowed, clock, reset, rsp_valid_ff && rsp_untracked,
      rsp_allowed && rsp_request_count == '0)
   `PCWRL_ASSERT_IMPLIES(a_deny_tracked, clock, reset, rsp_valid_ff && !rsp_allowed,
      !rsp_untracked && rsp_request_count != '0)

endmodule

>>> rtl/per_client_window_rate_limiter_core.sv
// Per-client fixed-window rate limiter. A transaction (client key, timestamp) is
// accepted when start is high and busy is low. With limiting on, the block sweeps
// its TABLE_ENTRIES-entry client table one entry per clock, dropping run-out
// windows and looking up the client in the same pass, then commits the table
// update in the update state; the result strobes on rsp_valid for exactly one
// clock in the cycle after that, and the receiver cannot stall it. A new
// transaction is taken only once the previous one has finished its sweep and
// update, as the single table read port is walked by the sweep counter; with
// limit_per_window at 0 the sweep is skipped. busy may drop while a result is
// still strobing, so the next transaction can be taken in that cycle.
// Configuration: limit_per_window at byte address 0, window_ticks at 4; write
// only while idle.
module per_client_window_rate_limiter_core import pcwrl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  start,
   output logic                  busy,
   input  logic [KEY_W-1:0]      req_client_key,
   input  logic [TIME_W-1:0]     req_now_time,
   // result channel
   output logic                  rsp_valid,
   output logic                  rsp_allowed,
   output logic                  rsp_untracked,
   output logic [CNT_W-1:0]      rsp_request_count,
   // configuration port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [LIMIT_W-1:0] limit_per_window;
   logic [WIN_W-1:0]   window_ticks;
   cmd_type            cmd;
   status_type         status;

   // configuration registers
   pcwrl_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .limit_per_window (limit_per_window),
      .window_ticks     (window_ticks)
   );

   // sequencer: idle -> sweep (one entry per clock) -> update; sweep skipped with limiting off
   pcwrl_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // client table, search registers and result registers
   pcwrl_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .limit_per_window  (limit_per_window),
      .window_ticks      (window_ticks),
      .req_client_key    (req_client_key),
      .req_now_time      (req_now_time),
      .rsp_valid         (rsp_valid),
      .rsp_allowed       (rsp_allowed),
      .rsp_untracked     (rsp_untracked),
      .rsp_request_count (rsp_request_count)
   );

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for per_client_window_rate_limiter_core.
//
// Flow:
//   1. Directed table: limiting off after reset, the smallest window with
//      denial, expiry and timestamp wrap, then a table fill up to the
//      untracked case. A few rows carry a hand-typed result; the rest go
//      through the scoreboard model.
//   2. Random phases: each phase first drains the block, then reprograms
//      both registers (the limit and the window, extremes included), then
//      sends a burst of requests. Most of them come from a small pool of
//      clients, with time steps scaled to the window so that entries
//      expire, hit and fill the table. A few use a random key or jump to a
//      random time.
//   3. Burst: one client hammered at a single tick with a small limit, so
//      the count walks past the limit and the later requests are denied.
//
// Requests are driven at the rising edge. A transaction is taken at the
// edge where start is high and busy is low. Results cannot be held off, so
// the checker samples rsp_valid on every edge and compares each result
// against the oldest queued expectation.
module tb;
   import pcwrl_pkg::*;

   localparam int CYCLE_LIMIT   = 400_000;  // a full run with the longest gaps stays well below this
   localparam int DRAIN_CYCLES  = TABLE_ENTRIES + 4;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS   = 140;
   localparam int SAT_ITEMS     = 40;       // well past the burst limit
   localparam int POOL_MAX      = 24;       // larger than the table, so it can fill

   typedef struct packed {
      logic             allowed;
      logic             untracked;
      logic [CNT_W-1:0] count;
   } verdict_type;

   typedef enum logic [1:0] {
      ROW_REQ,
      ROW_SET_LIMIT,
      ROW_SET_WINDOW
   } row_kind_type;

   // For the register rows, stamp holds the value to be written.
   typedef struct packed {
      row_kind_type      kind;
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] stamp;
      logic              typed;
      verdict_type       want;
   } row_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [KEY_W-1:0]      req_client_key;
   logic [TIME_W-1:0]     req_now_time;
   logic                  rsp_valid;
   logic                  rsp_allowed;
   logic                  rsp_untracked;
   logic [CNT_W-1:0]      rsp_request_count;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Scoreboard model: register shadows and the client table.
   logic [LIMIT_W-1:0] limit_shadow;
   logic [WIN_W-1:0]   window_shadow;
   logic               client_valid [TABLE_ENTRIES];
   logic [KEY_W-1:0]   client_key   [TABLE_ENTRIES];
   logic [CNT_W-1:0]   client_count [TABLE_ENTRIES];
   logic [TIME_W-1:0]  client_start [TABLE_ENTRIES];

   verdict_type pending_verdicts[$];
   int          fail_count = 0;
   int          cycle_count = 0;

   per_client_window_rate_limiter_core uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_client_key    (req_client_key),
      .req_now_time      (req_now_time),
      .rsp_valid         (rsp_valid),
      .rsp_allowed       (rsp_allowed),
      .rsp_untracked     (rsp_untracked),
      .rsp_request_count (rsp_request_count),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Model of one request. It sweeps out expired windows, then does the
   // lookup or the allocation. With limiting off the table is left alone.
   function automatic verdict_type judge_request(input logic [KEY_W-1:0] key,
                                                 input logic [TIME_W-1:0] stamp);
      verdict_type       v;
      int                hit;
      int                free_idx;
      logic [TIME_W-1:0] elapsed;
      logic [CNT_W-1:0]  cnt;
      v.allowed   = 1'b1;
      v.untracked = 1'b0;
      v.count     = '0;
      hit         = -1;
      free_idx    = -1;
      if (limit_shadow == '0)
         return v;
      // elapsed wraps mod 2^32; expiry is strictly past the window
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         elapsed = stamp - client_start[i];
         if (client_valid[i] && elapsed > TIME_W'(window_shadow))
            client_valid[i] = 1'b0;
      end
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (client_valid[i]) begin
            if (hit < 0 && client_key[i] == key)
               hit = i;
         end else if (free_idx < 0) begin
            free_idx = i;
         end
      end
      if (hit >= 0) begin
         // denied requests still count; the count stops at its ceiling
         cnt = client_count[hit];
         if (cnt < COUNT_MAX)
            cnt = cnt + 1'b1;
         client_count[hit] = cnt;
         v.allowed = (cnt <= CNT_W'(limit_shadow));
         v.count   = cnt;
      end else if (free_idx >= 0) begin
         // lowest free entry, new window from this tick
         client_valid[free_idx] = 1'b1;
         client_key[free_idx]   = key;
         client_count[free_idx] = CNT_W'(1);
         client_start[free_idx] = stamp;
         v.count = CNT_W'(1);
      end else begin
         v.untracked = 1'b1;
      end
      return v;
   endfunction

   function automatic row_type make_row(input row_kind_type kind,
                                        input logic [KEY_W-1:0] key,
                                        input logic [TIME_W-1:0] stamp, input int typed,
                                        input int allowed, input int untracked,
                                        input int count);
      row_type r;
      r.kind           = kind;
      r.key            = key;
      r.stamp          = stamp;
      r.typed          = (typed != 0);
      r.want.allowed   = (allowed != 0);
      r.want.untracked = (untracked != 0);
      r.want.count     = CNT_W'(count);
      return r;
   endfunction

   // Wait gap cycles, then raise start until the block takes the transaction.
   // start stays high on return, so a request that follows with no gap goes
   // out in the next cycle without a glitch.
   task automatic issue_request(input logic [KEY_W-1:0] key, input logic [TIME_W-1:0] stamp,
                                input int gap, input logic typed, input verdict_type want);
      verdict_type v;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_client_key <= key;
      req_now_time   <= stamp;
      do @(posedge clock); while (busy);
      v = judge_request(key, stamp);
      pending_verdicts.push_back(typed ? want : v);
   endtask

   // Stop sending and wait until every outstanding result is back.
   task automatic settle_block();
      start <= 1'b0;
      while (pending_verdicts.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic csr_read(input logic [CSR_ADDR_W-1:0] addr,
                           output logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      data = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Write one register, update the shadow, then read it back and compare.
   task automatic program_register(input logic reg_sel, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_ADDR_W-1:0] addr;
      logic [CSR_DATA_W-1:0] readback;
      logic [CSR_DATA_W-1:0] want;
      addr = {reg_sel, 2'b00};
      csr_write(addr, value);
      if (reg_sel == REG_LIMIT) begin
         limit_shadow = value[LIMIT_W-1:0];
         want = CSR_DATA_W'(limit_shadow);
      end else begin
         window_shadow = value[WIN_W-1:0];
         want = CSR_DATA_W'(window_shadow);
      end
      csr_read(addr, readback);
      if (readback !== want) begin
         $display("%0t: register at %0d reads back wrong: expected %0h, got %0h",
                  $time, addr, want, readback);
         fail_count++;
      end
   endtask

   // Results cannot be held off: check each strobe against the oldest
   // expectation.
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t: result with no transaction outstanding: %s %0b %0b %0d",
                     $time, "expected none, got", rsp_allowed, rsp_untracked,
                     rsp_request_count);
            fail_count++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_allowed !== want.allowed) begin
               $display("%0t: allowed mismatch: expected %0b, got %0b",
                        $time, want.allowed, rsp_allowed);
               fail_count++;
            end
            if (rsp_untracked !== want.untracked) begin
               $display("%0t: untracked mismatch: expected %0b, got %0b",
                        $time, want.untracked, rsp_untracked);
               fail_count++;
            end
            if (rsp_request_count !== want.count) begin
               $display("%0t: request_count mismatch: expected %0d, got %0d",
                        $time, want.count, rsp_request_count);
               fail_count++;
            end
         end
      end
   end

   initial begin : stimulus
      row_type           rows[$];
      logic [KEY_W-1:0]  key_pool [POOL_MAX];
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] stamp;
      int unsigned       w;
      int                pool_n;
      int                idle_on;
      int                roll;
      logic [LIMIT_W-1:0] lim;
      logic [WIN_W-1:0]   win;

      reset          = 1'b1;
      start          = 1'b0;
      req_client_key = '0;
      req_now_time   = '0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;

      limit_shadow  = '0;
      window_shadow = WINDOW_RESET;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         client_valid[i] = 1'b0;
         client_key[i]   = '0;
         client_count[i] = '0;
         client_start[i] = '0;
      end

      // --- directed table ---
      // limiting off after reset: always allowed, count 0, table untouched
      rows.push_back(make_row(ROW_REQ, 32'h0000_0000, 32'h0000_0000, 1, 1, 0, 0));
      rows.push_back(make_row(ROW_REQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 0, 0));
      // limit 1, shortest window
      rows.push_back(make_row(ROW_SET_LIMIT, '0, 32'd1, 0, 0, 0, 0));
      rows.push_back(make_row(ROW_SET_WINDOW, '0, 32'd1, 0, 0, 0, 0));
      rows.push_back(make_row(ROW_REQ, 32'd5, 32'd10, 1, 1, 0, 1));
      // elapsed 1 is still inside the window: over the limit, denied
      rows.push_back(make_row(ROW_REQ, 32'd5, 32'd11, 1, 0, 0, 2));
      // elapsed 2 is past the window: fresh window
      rows.push_back(make_row(ROW_REQ, 32'd5, 32'd12, 1, 1, 0, 1));
      // timestamp wrap: FFFFFFFF -> 0 is one tick
      rows.push_back(make_row(ROW_REQ, 32'd6, 32'hFFFF_FFFF, 0, 0, 0, 0));
      rows.push_back(make_row(ROW_REQ, 32'd6, 32'h0000_0000, 1, 0, 0, 2));
      // largest limit and window; fill the table (client 6 holds one entry)
      rows.push_back(make_row(ROW_SET_LIMIT, '0, 32'h0000_FFFF, 0, 0, 0, 0));
      rows.push_back(make_row(ROW_SET_WINDOW, '0, 32'h7FFF_FFFF, 0, 0, 0, 0));
      for (int i = 0; i < TABLE_ENTRIES - 1; i++)
         rows.push_back(make_row(ROW_REQ,
                                 (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : 32'h100 + i,
                                 32'h1000, 0, 0, 0, 0));
      // table full, new client: allowed but not recorded
      rows.push_back(make_row(ROW_REQ, 32'hABCD_0123, 32'h1000, 1, 1, 1, 0));
      // a tracked client still hits
      rows.push_back(make_row(ROW_REQ, 32'd6, 32'h1000, 0, 0, 0, 0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         case (rows[i].kind)
            ROW_REQ: begin
               issue_request(rows[i].key, rows[i].stamp, $urandom_range(0, 14),
                             rows[i].typed, rows[i].want);
            end
            ROW_SET_LIMIT: begin
               settle_block();
               program_register(REG_LIMIT, rows[i].stamp);
            end
            default: begin
               settle_block();
               program_register(REG_WINDOW, rows[i].stamp);
            end
         endcase
      end

      // --- random phases ---
      // Each phase drains first, so the sender is held off until every
      // result is back before the registers change.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settle_block();
         case (p % 6)
            0:       lim = LIMIT_W'(1);
            1:       lim = LIMIT_W'(2);
            2:       lim = LIMIT_W'($urandom_range(3, 8));
            3:       lim = '0;
            4:       lim = 16'hFFFF;
            default: lim = LIMIT_W'($urandom_range(1, 4));
         endcase
         case (p % 4)
            0:       win = WIN_W'(1);
            1:       win = WIN_W'($urandom_range(2, 64));
            2:       win = WIN_W'($urandom_range(1000, 1_000_000));
            default: win = 31'h7FFF_FFFF;
         endcase
         program_register(REG_WINDOW, CSR_DATA_W'(win));
         program_register(REG_LIMIT, CSR_DATA_W'(lim));

         pool_n = $urandom_range(2, POOL_MAX);
         for (int k = 0; k < POOL_MAX; k++)
            key_pool[k] = $urandom();
         idle_on = ($urandom_range(0, 3) != 0);
         w       = 32'(window_shadow);
         stamp   = $urandom();

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            // mostly short steps inside the window, some around its edge,
            // a few jumps anywhere
            if (roll < 5)
               stamp = $urandom();
            else if (roll < 15)
               stamp = stamp + $urandom_range(w / 2, w + 2);
            else
               stamp = stamp + $urandom_range(0, w / 8 + 1);
            if ($urandom_range(0, 9) == 0)
               key = $urandom();
            else
               key = key_pool[$urandom_range(0, pool_n - 1)];
            issue_request(key, stamp, idle_on ? $urandom_range(0, 14) : 0, 1'b0, '0);
         end
      end

      // --- burst ---
      // Shortest window, all at one tick: the first request sweeps nearly
      // everything out, and the client's window then never runs out. The
      // count walks past the limit and the rest of the burst is denied.
      settle_block();
      program_register(REG_WINDOW, 32'd1);
      program_register(REG_LIMIT, 32'd16);
      key   = $urandom();
      stamp = $urandom();
      repeat (SAT_ITEMS) issue_request(key, stamp, 0, 1'b0, '0);

      settle_block();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
